/* rtl/dtt_pkg.sv */
// Shared types and constants for the deadline timer table.
// Holds field layout, operation codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package dtt_pkg;

  localparam int TIME_BITS   = 32;
  localparam int ID_W        = 4;
  localparam int DUR_W       = 31;
  localparam int OP_W        = 2;
  localparam int WIN_W       = 16;
  localparam int OUT_TIME_W  = 32;
  localparam int RESULT_CAP  = 16;
  localparam int RES_CNT_W   = 5;

  // Input tdata layout: timer_id, duration_ms, now_ms, zero fill.
  localparam int ID_LSB      = 0;
  localparam int DUR_LSB     = ID_LSB + ID_W;
  localparam int NOW_LSB     = DUR_LSB + DUR_W;
  localparam int IN_USED_W   = NOW_LSB + TIME_BITS;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout: expired_id, expired_deadline, zero fill.
  localparam int OUT_USED_W  = ID_W + OUT_TIME_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd300;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [OP_W-1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_EXPIRE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ARM_RD,
    ST_ARM_CMP,
    ST_ARM_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic cancel;
    logic arm_key;
    logic arm_diff;
    logic arm_write;
    logic scan_clear;
    logic scan_issue;
    logic res_clear;
    logic take_best;
    logic push_out;
    logic push_last;
    logic hold_clear;
  } dtt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic id_ok;
    logic found;
    logic hold_valid;
    logic out_free;
    logic cap_next;
    logic scan_last;
  } dtt_sts_t;

endpackage

/* rtl/dtt_ctrl.sv */
// Controller state machine for the deadline timer table.
// Sequences arm, cancel and expire scans; drives dtt_datapath through
// dtt_pkg::dtt_cmd_t and reads dtt_pkg::dtt_sts_t.
module dtt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dtt_pkg::dtt_sts_t sts,
  output dtt_pkg::dtt_cmd_t cmd
);

  dtt_pkg::state_t state_r;
  dtt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dtt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = dtt_pkg::ST_DISPATCH;
        end
      end
      dtt_pkg::ST_DISPATCH: begin
        unique case (sts.op)
          dtt_pkg::OP_ARM: begin
            state_nxt = sts.id_ok ? dtt_pkg::ST_ARM_RD : dtt_pkg::ST_IDLE;
          end
          dtt_pkg::OP_CANCEL: begin
            cmd.cancel = 1'b1;
            state_nxt  = dtt_pkg::ST_IDLE;
          end
          dtt_pkg::OP_EXPIRE: begin
            cmd.scan_clear = 1'b1;
            cmd.res_clear  = 1'b1;
            state_nxt      = dtt_pkg::ST_SCAN;
          end
          default: begin
            state_nxt = dtt_pkg::ST_IDLE;
          end
        endcase
      end
      dtt_pkg::ST_ARM_RD: begin
        cmd.arm_key = 1'b1;
        state_nxt   = dtt_pkg::ST_ARM_CMP;
      end
      dtt_pkg::ST_ARM_CMP: begin
        cmd.arm_diff = 1'b1;
        state_nxt    = dtt_pkg::ST_ARM_WR;
      end
      dtt_pkg::ST_ARM_WR: begin
        cmd.arm_write = 1'b1;
        state_nxt     = dtt_pkg::ST_IDLE;
      end
      dtt_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = dtt_pkg::ST_SCAN_END;
        end
      end
      dtt_pkg::ST_SCAN_END: begin
        state_nxt = dtt_pkg::ST_DECIDE;
      end
      dtt_pkg::ST_DECIDE: begin
        if (sts.found) begin
          if (!sts.hold_valid || sts.out_free) begin
            // release the previous pick as a non-final beat, keep the new one
            cmd.take_best = 1'b1;
            cmd.push_out  = sts.hold_valid;
            if (sts.cap_next) begin
              state_nxt = dtt_pkg::ST_FLUSH;
            end else begin
              cmd.scan_clear = 1'b1;
              state_nxt      = dtt_pkg::ST_SCAN;
            end
          end
        end else if (!sts.hold_valid) begin
          state_nxt = dtt_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push_out   = 1'b1;
          cmd.push_last  = 1'b1;
          cmd.hold_clear = 1'b1;
          state_nxt      = dtt_pkg::ST_IDLE;
        end
      end
      dtt_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.push_out   = 1'b1;
          cmd.push_last  = 1'b1;
          cmd.hold_clear = 1'b1;
          state_nxt      = dtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtt_pkg::ST_IDLE) |-> !sts.hold_valid)
    else $error("pending result left behind on return to idle");
`endif

endmodule

/* rtl/dtt_datapath.sv */
// Datapath for the deadline timer table: item registers, deadline memory,
// armed bits, minimum-search scan, pending result and output register.
// Uses dtt_pkg types; commanded by dtt_ctrl.
module dtt_datapath #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dtt_pkg::dtt_cmd_t               cmd,
  output dtt_pkg::dtt_sts_t               sts,
  input  logic [dtt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [dtt_pkg::OP_W-1:0]        in_tuser,
  input  logic [dtt_pkg::WIN_W-1:0]       lazy_window,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dtt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int TB     = dtt_pkg::TIME_BITS;

  // item registers
  dtt_pkg::op_t              op_r;
  logic [dtt_pkg::ID_W-1:0]  id_r;
  logic [dtt_pkg::DUR_W-1:0] dur_r;
  dtt_pkg::time_t            now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= dtt_pkg::op_t'(in_tuser);
      id_r  <= in_tdata[dtt_pkg::ID_LSB +: dtt_pkg::ID_W];
      dur_r <= in_tdata[dtt_pkg::DUR_LSB +: dtt_pkg::DUR_W];
      now_r <= in_tdata[dtt_pkg::NOW_LSB +: TB];
    end
  end

  logic [SLOT_W-1:0] id_slot;
  logic              id_ok;
  assign id_slot = SLOT_W'(id_r);
  assign id_ok   = (int'(id_r) < TIMER_SLOTS);

  // deadline memory and armed bits
  dtt_pkg::time_t    dl_mem [TIMER_SLOTS];
  dtt_pkg::time_t    rd_data_r;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] scan_cnt_r;
  logic [TIMER_SLOTS-1:0] armed_r;

  dtt_pkg::time_t key_r;
  dtt_pkg::time_t diff_r;
  dtt_pkg::time_t mag;
  logic           keep;
  logic           arm_we;

  assign rd_addr = cmd.scan_issue ? scan_cnt_r : id_slot;
  assign mag     = diff_r[TB-1] ? (-diff_r) : diff_r;
  assign keep    = armed_r[id_slot] && (mag < TB'(lazy_window));
  assign arm_we  = cmd.arm_write && id_ok && !keep;

  always_ff @(posedge clk) begin
    if (arm_we) begin
      dl_mem[id_slot] <= key_r;
    end
    rd_data_r <= dl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.arm_key) begin
      key_r <= now_r + TB'(dur_r);
    end
    if (cmd.arm_diff) begin
      diff_r <= key_r - rd_data_r;
    end
  end

  // scan: address stage, then compare against best
  logic              scan_pv_r;
  logic [SLOT_W-1:0] scan_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pv_r <= 1'b0;
    end else begin
      scan_pv_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_cnt_r;
    if (cmd.scan_clear) begin
      scan_cnt_r <= '0;
    end else if (cmd.scan_issue) begin
      scan_cnt_r <= scan_cnt_r + SLOT_W'(1);
    end
  end

  dtt_pkg::time_t    sd;
  dtt_pkg::time_t    skey;
  logic              due;
  logic              better;
  logic              best_found_r;
  dtt_pkg::time_t    best_key_r;
  dtt_pkg::time_t    best_dl_r;
  logic [SLOT_W-1:0] best_idx_r;

  assign sd     = rd_data_r - now_r;
  assign skey   = sd ^ {1'b1, {(TB-1){1'b0}}};
  assign due    = scan_pv_r && armed_r[scan_idx_r] && ((sd == '0) || sd[TB-1]);
  assign better = due && (!best_found_r || (skey < best_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd.scan_clear) begin
      best_found_r <= 1'b0;
    end else if (better) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_key_r <= skey;
      best_dl_r  <= rd_data_r;
      best_idx_r <= scan_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else begin
      if (arm_we) begin
        armed_r[id_slot] <= 1'b1;
      end
      if (cmd.cancel && id_ok) begin
        armed_r[id_slot] <= 1'b0;
      end
      if (cmd.take_best) begin
        armed_r[best_idx_r] <= 1'b0;
      end
    end
  end

  // pending result and result count
  logic                          hold_valid_r;
  logic [SLOT_W-1:0]             hold_id_r;
  dtt_pkg::time_t                hold_dl_r;
  logic [dtt_pkg::RES_CNT_W-1:0] res_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (cmd.take_best) begin
      hold_valid_r <= 1'b1;
    end else if (cmd.hold_clear) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_best) begin
      hold_id_r <= best_idx_r;
      hold_dl_r <= best_dl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
    end else if (cmd.res_clear) begin
      res_cnt_r <= '0;
    end else if (cmd.take_best) begin
      res_cnt_r <= res_cnt_r + dtt_pkg::RES_CNT_W'(1);
    end
  end

  // output register
  logic                            out_valid_r;
  logic [dtt_pkg::ID_W-1:0]        out_id_r;
  logic [dtt_pkg::OUT_TIME_W-1:0]  out_dl_r;
  logic                            out_last_r;
  logic                            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      out_id_r   <= dtt_pkg::ID_W'(hold_id_r);
      out_dl_r   <= dtt_pkg::OUT_TIME_W'(hold_dl_r);
      out_last_r <= cmd.push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{dtt_pkg::OUT_PAD_W{1'b0}}, out_dl_r, out_id_r};

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.id_ok      = id_ok;
    sts.found      = best_found_r;
    sts.hold_valid = hold_valid_r;
    sts.out_free   = out_free;
    sts.cap_next   = (res_cnt_r == dtt_pkg::RES_CNT_W'(dtt_pkg::RESULT_CAP - 1));
    sts.scan_last  = (scan_cnt_r == SLOT_W'(TIMER_SLOTS - 1));
  end

`ifndef SYNTHESIS
  a_take_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_best |-> best_found_r)
    else $error("slot taken without a due candidate");
  a_take_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_best |=> !armed_r[$past(best_idx_r)])
    else $error("expired slot still armed");
  a_push_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_out |-> (hold_valid_r && out_free))
    else $error("result pushed without pending entry or free output");
  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= dtt_pkg::RES_CNT_W'(dtt_pkg::RESULT_CAP))
    else $error("result count beyond cap");
`endif

endmodule

/* rtl/deadline_timer_table_core.sv */
// Top level of the deadline timer table: stream ports, lazy window register,
// controller and datapath. Depends on dtt_pkg, dtt_ctrl and dtt_datapath.
//
// Usage:
//   in_*  : one beat per request. in_tuser selects arm, cancel or expire
//           check; in_tdata carries timer_id, duration_ms and now_ms.
//   out_* : one beat per expired slot, most overdue first, ties to the lower
//           slot; out_tlast marks the final beat of a check. A check with
//           nothing due yields no beat.
//   cfg_* : write of lazy_window_ms, always ready; write only while idle.
// Sequencing:
//   arm reads, compares and writes its slot; cancel, an unknown operation
//   or a bad slot finish at dispatch. An expire check runs one pass over
//   the deadline memory per pick (one read port, one slot per cycle) and
//   stops once it hits the cap of 16 beats.
// Reset clears all armed flags and loads a lazy window of 300; deadline
// storage is not cleared. A stalled receiver holds the output register; the
// next pass then waits before pushing, but a finished check lets the block
// take its next request while the final beat still waits.
module deadline_timer_table_core #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] timer_id, [34:4] duration_ms, [66:35] now_ms, [71:67] zero
  input  logic [dtt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [dtt_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] expired_id, [35:4] expired_deadline, [39:36] zero
  output logic [dtt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtt_pkg::WIN_W-1:0]       cfg_data
);

  dtt_pkg::dtt_cmd_t           cmd;
  dtt_pkg::dtt_sts_t           sts;
  logic [dtt_pkg::WIN_W-1:0]   lazy_window_r;

  // Configuration is always accepted and registered into the lazy window.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lazy_window_r <= dtt_pkg::WIN_RESET;
    end else if (cfg_valid) begin
      lazy_window_r <= cfg_data;
    end
  end

  // Sequence each request: dispatch, arm read-compare-write, scan passes.
  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the table, run the minimum search and drive the output beat.
  dtt_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .lazy_window (lazy_window_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

/* test/dtt_expiry_checker.sv */
// Checker for the deadline timer table: mirrors the slot table from the
// request and window-write beats and matches each expiry beat in order.
// Depends on dtt_pkg.
module dtt_expiry_checker
  import dtt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [WIN_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0] id;
    time_t           deadline;
    logic            last;
  } expiry_t;

  expiry_t          expiry_q[$];
  time_t            slot_deadline[SLOTS];
  logic [SLOTS-1:0] slot_armed;
  logic [WIN_W-1:0] lazy_window;

  function automatic time_t gap_magnitude(input time_t d);
    time_t neg;
    neg = -d;
    return d[TIME_BITS-1] ? neg : d;
  endfunction

  // Emit due slots most overdue first, lower slot on a tie.
  task automatic release_due(input time_t now);
    int      best;
    int      emitted;
    time_t   best_rank;
    time_t   gap;
    time_t   rank;
    expiry_t tail;
    emitted = 0;
    for (int n = 0; n < RESULT_CAP; n++) begin
      best = -1;
      best_rank = '0;
      for (int s = 0; s < SLOTS; s++) begin
        gap  = slot_deadline[s] - now;
        rank = {~gap[TIME_BITS-1], gap[TIME_BITS-2:0]};
        if (slot_armed[s] && (gap == '0 || gap[TIME_BITS-1]) &&
            (best < 0 || rank < best_rank)) begin
          best = s;
          best_rank = rank;
        end
      end
      if (best < 0) break;
      slot_armed[best] = 1'b0;
      expiry_q.push_back('{id: best[ID_W-1:0], deadline: slot_deadline[best], last: 1'b0});
      emitted++;
    end
    if (emitted > 0) begin
      tail = expiry_q.pop_back();
      tail.last = 1'b1;
      expiry_q.push_back(tail);
    end
  endtask

  task automatic apply_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [DUR_W-1:0] dur, input time_t now);
    time_t key;
    case (op)
      OP_ARM: begin
        key = now + time_t'(dur);
        // keep the old deadline when the re-arm lands inside the lazy window
        if (!(slot_armed[id] &&
              gap_magnitude(key - slot_deadline[id]) < time_t'(lazy_window))) begin
          slot_deadline[id] = key;
          slot_armed[id] = 1'b1;
        end
      end
      OP_CANCEL: slot_armed[id] = 1'b0;
      OP_EXPIRE: release_due(now);
      default: ;
    endcase
  endtask

  task automatic check_beat();
    expiry_t         want;
    logic [ID_W-1:0] got_id;
    time_t           got_deadline;
    got_id       = out_tdata[0 +: ID_W];
    got_deadline = out_tdata[ID_W +: OUT_TIME_W];
    beats_checked++;
    if (expiry_q.size() == 0) begin
      fail_count++;
      $display("%0t ns: expiry beat with none expected, got id %0d deadline %h last %b",
               $time, got_id, got_deadline, out_tlast);
    end else begin
      want = expiry_q.pop_front();
      if (got_id !== want.id || got_deadline !== want.deadline || out_tlast !== want.last) begin
        fail_count++;
        $display("%0t ns: expected id %0d dl %h last %b, got id %0d dl %h last %b",
                 $time, want.id, want.deadline, want.last, got_id, got_deadline, out_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_armed    = '0;
      lazy_window   = WIN_RESET;
      fail_count    = 0;
      beats_checked = 0;
      expiry_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) lazy_window = cfg_data;
      if (in_tvalid && in_tready)
        apply_request(in_tuser, in_tdata[ID_LSB +: ID_W], in_tdata[DUR_LSB +: DUR_W],
                      in_tdata[NOW_LSB +: TIME_BITS]);
      if (out_tvalid && out_tready) check_beat();
    end
    pending = expiry_q.size();
  end

endmodule

/* test/tb_deadline_timer_table_core.sv */
// Testbench top for deadline_timer_table_core: drives request and window-write
// beats, stalls the expiry stream at random and reports the verdict.
// Depends on dtt_pkg, dtt_expiry_checker and the block itself.
module tb_deadline_timer_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dtt_pkg::*;

  localparam int SLOTS = 16;
  // operation code the block must ignore
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [3:0] timer_id, [34:4] duration_ms, [66:35] now_ms, [71:67] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [1:0] operation
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [3:0] expired_id, [35:4] expired_deadline, [39:36] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [WIN_W-1:0]       cfg_data;

  int fail_count;
  int pending;
  int beats_checked;

  // Stimulus bookkeeping. recent_key only steers re-arms near an earlier
  // deadline; it is not a prediction and may be stale.
  int               idle_odds;
  int               stall_left;
  int               arm_count;
  int               cancel_count;
  int               check_count;
  int               reserved_count;
  time_t            clock_ms;
  time_t            recent_key[SLOTS];
  logic [WIN_W-1:0] cur_window;

  deadline_timer_table_core #(
    .TIMER_SLOTS(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Watch all three channels, predict and compare; only counts come back.
  dtt_expiry_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .beats_checked(beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every check flushing the
  // full table, each beat held by the longest receiver stall).
  initial begin
    #2_000_000;
    $display("Timeout with %0d expiry beats still outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver side: drop tready in random bursts while idling is enabled,
  // otherwise hold it high.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Present one request beat and hold it until accepted. Leave tvalid high
  // on return so back-to-back beats need no extra edge; an optional idle
  // burst before the beat drops it first.
  task automatic issue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                       input logic [DUR_W-1:0] dur, input time_t now);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    word = '0;
    word[ID_LSB +: ID_W]       = id;
    word[DUR_LSB +: DUR_W]     = dur;
    word[NOW_LSB +: TIME_BITS] = now;
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    case (op)
      OP_ARM:    arm_count++;
      OP_CANCEL: cancel_count++;
      OP_EXPIRE: check_count++;
      default:   reserved_count++;
    endcase
  endtask

  // Write the lazy window only with the block idle: drain every expected
  // beat, then let a trailing arm or empty check finish before the write.
  task automatic write_window(input logic [WIN_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_window = value;
  endtask

  // Directed corners: empty check, idle cancel, lazy keep, deadline ties,
  // half-range re-arm, wrap of the time base, reserved opcode, window
  // extremes and a check that expires the whole table.
  task automatic run_directed();
    issue(OP_EXPIRE, 4'd0, '0, 32'd0);                      // nothing armed
    issue(OP_CANCEL, 4'd5, '0, 32'd0);                      // cancel idle slot
    issue(OP_ARM, 4'd0, 31'd100, 32'd0);
    issue(OP_ARM, 4'd0, 31'd350, 32'd0);                    // 250 away: keep 100
    issue(OP_ARM, 4'd1, 31'd100, 32'd0);                    // ties slot 0
    issue(OP_ARM, 4'd2, 31'd0, 32'd50);
    issue(OP_ARM, 4'd15, 31'h7FFF_FFFF, 32'hFFFF_FFF0);     // far ahead, wraps
    issue(OP_RESERVED, 4'hF, 31'h7FFF_FFFF, 32'hFFFF_FFFF); // ignored
    issue(OP_EXPIRE, 4'hF, 31'h7FFF_FFFF, 32'd100);         // slots 2, 0, 1
    issue(OP_ARM, 4'd3, 31'd100, 32'd0);
    issue(OP_ARM, 4'd3, 31'h7FFF_FFFF, 32'd101);            // exactly half range away
    issue(OP_EXPIRE, 4'd0, '0, 32'h8000_0064);              // slots 15, 3

    // A zero window never keeps the old deadline.
    write_window(16'd0);
    issue(OP_ARM, 4'd6, 31'd10, 32'd1000);
    issue(OP_ARM, 4'd6, 31'd11, 32'd1000);

    // Widest window keeps a re-arm 65534 away.
    write_window(16'hFFFF);
    issue(OP_ARM, 4'd6, 31'd65534, 32'd1011);
    issue(OP_ARM, 4'd7, 31'h200, 32'hFFFF_FF00);            // deadline wraps to 0x100
    issue(OP_EXPIRE, 4'd0, '0, 32'h0000_1000);              // slots 7, 6

    // Fill the whole table and expire it in one check.
    for (int s = 0; s < SLOTS; s++)
      issue(OP_ARM, s[ID_W-1:0], DUR_W'($urandom_range(0, 40)), 32'h4000_0000);
    issue(OP_EXPIRE, 4'd0, '0, 32'h4000_0040);
  endtask

  // Mostly arms with short durations against a creeping clock, so checks
  // find work; re-arms aim around the lazy window edge; rare clock jumps
  // and full-width durations exercise the signed wrap compare.
  task automatic run_random(input int count);
    int               pick;
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] dur;
    time_t            target;
    time_t            ahead;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      id   = ID_W'($urandom_range(0, SLOTS - 1));
      clock_ms += $urandom_range(0, 300);
      if (pick < 4) clock_ms = $urandom;
      if (pick < 40) begin
        if ($urandom_range(0, 9) == 0) dur = DUR_W'($urandom);
        else dur = DUR_W'($urandom_range(0, 1500));
        issue(OP_ARM, id, dur, clock_ms);
        recent_key[id] = clock_ms + time_t'(dur);
      end else if (pick < 55) begin
        target = recent_key[id] + time_t'($urandom_range(0, 2 * cur_window + 8))
                 - time_t'(cur_window + 4);
        ahead = target - clock_ms;
        // fall back to an immediate deadline when the target is behind now
        dur = ahead[TIME_BITS-1] ? '0 : ahead[DUR_W-1:0];
        issue(OP_ARM, id, dur, clock_ms);
      end else if (pick < 68) begin
        issue(OP_CANCEL, id, DUR_W'($urandom), clock_ms);
      end else if (pick < 95) begin
        issue(OP_EXPIRE, id, DUR_W'($urandom), clock_ms);
      end else begin
        issue(OP_RESERVED, id, DUR_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_ARM;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    idle_odds      = 4;
    arm_count      = 0;
    cancel_count   = 0;
    check_count    = 0;
    reserved_count = 0;
    clock_ms       = '0;
    cur_window     = WIN_RESET;
    for (int s = 0; s < SLOTS; s++) recent_key[s] = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    write_window(WIN_W'($urandom_range(0, 65535)));
    idle_odds = 3;
    run_random(50);

    // No idling here; start just below the wrap of the time base.
    write_window(16'd0);
    idle_odds = 0;
    clock_ms  = 32'hFFFF_F800;
    run_random(50);

    write_window(16'hFFFF);
    idle_odds = 5;
    run_random(50);

    // Final stretch runs at full rate on both sides.
    write_window(WIN_W'($urandom_range(1, 2000)));
    idle_odds = 0;
    run_random(50);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);

    $display("Covered %0d requests: %0d arm, %0d cancel, %0d expire check, %0d reserved op",
             arm_count + cancel_count + check_count + reserved_count,
             arm_count, cancel_count, check_count, reserved_count);
    $display("Matched %0d expiry beats under lazy windows of 0, 300, 65535 and random values",
             beats_checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dtt_pkg.sv
rtl/dtt_ctrl.sv
rtl/dtt_datapath.sv
rtl/deadline_timer_table_core.sv
test/dtt_expiry_checker.sv
test/tb_deadline_timer_table_core.sv
